// ===== hdl/assert_macros.svh =====
// assertion macros shared by the deframer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define VTD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("vtd assertion failed");

// expression must never be true outside reset
`define VTD_NEVER(lbl, clk, rst, expr) \
   `VTD_ASSERT(lbl, clk, rst, !(expr))

`endif

// ===== hdl/vtd_pkg.sv =====
// package with types and constants of the two-stream deframer
`default_nettype none

package vtd_pkg;

   localparam int PAYLOAD_WORDS = 1024;
   localparam int POS_W = 15;
   localparam int IDX_W = 14;
   localparam int WORD_W = 32;

   localparam logic [POS_W-1:0] HDR_POS = POS_W'(0);
   localparam logic [POS_W-1:0] SID_POS = POS_W'(1);
   localparam logic [POS_W-1:0] PAY_POS = POS_W'(5);
   localparam logic [POS_W-1:0] PAY_END = POS_W'(5 + PAYLOAD_WORDS);
   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_WORDS - 1);

   localparam logic [3:0] TYPE_DATA = 4'h1;
   localparam logic [3:0] TYPE_CTXT = 4'h4;
   localparam logic [7:0] MISC_DATA = 8'h46;
   localparam logic [7:0] MISC_CTXT = 8'h16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 3;

   typedef enum logic [1:0] {
      ERR_NONE = 2'd0,
      ERR_TYPE = 2'd1,
      ERR_MISC = 2'd2
   } err_type;

   typedef struct packed {
      logic [WORD_W-1:0] payload_word;
      logic              stream_sel;
      logic [IDX_W-1:0]  sample_index;
      logic              last_of_packet;
      logic              set_complete;
      err_type           error_code;
   } result_type;

   typedef struct packed {
      logic       push;
      result_type entry;
   } push_type;

endpackage

`default_nettype wire

// ===== hdl/vrt_two_stream_deframer.sv =====
// top level of the two-stream packet deframer
//
// req channel: one 32-bit packet word per transaction in network byte order,
//   req_tlast marks the final word of a datagram. word 0 is the header,
//   word 1 the stream id, words 2 to 4 are skipped, then the payload.
// rsp channel: one transaction per payload word of a matched data packet,
//   or one error transaction for a bad header; other words give nothing.
// csr port: csr_wr_en loads the base stream id from csr_wr_data; write only
//   while idle.
// results: a result is written into the queue when its word is taken and is offered on rsp from the queue head.
// throughput: one word per cycle while the queue is not full, with a combinational decode in the
//   front part; a four-entry result queue sits between front and back.
// when rsp_tready is low the queue fills and req_tready drops once it holds
//   four results; nothing is lost.
// reset: queue empties, base id returns to 0, the next word is a header and
//   both stream flags clear.
`default_nettype none

module vrt_two_stream_deframer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [vtd_pkg::WORD_W-1:0]     csr_wr_data,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [vtd_pkg::WORD_W-1:0]     req_tdata,   // packet_word
   input  wire logic                           req_tlast,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // payload_word, sample_index, set_complete, zero pad
   output logic [vtd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // stream_sel, error_code
   output logic [vtd_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                rsp_tlast
);

   vtd_pkg::push_type push_bus;
   logic              queue_ready;

   assign req_tready = queue_ready;

   vtd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .word_valid  (req_tvalid),
      .word_data   (req_tdata),
      .word_eod    (req_tlast),
      .queue_ready (queue_ready),
      .push_out    (push_bus)
   );

   vtd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .push_in_bus (push_bus),
      .queue_ready (queue_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== hdl/vtd_front.sv =====
// front part: accepts packet words, decodes header and stream id, builds results
`default_nettype none
`include "assert_macros.svh"

module vtd_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [vtd_pkg::WORD_W-1:0] csr_wr_data,
   input  wire logic                       word_valid,
   input  wire logic [vtd_pkg::WORD_W-1:0] word_data,
   input  wire logic                       word_eod,
   input  wire logic                       queue_ready,
   output vtd_pkg::push_type               push_out
);

   logic [vtd_pkg::WORD_W-1:0] base_ff, base_in;
   logic [vtd_pkg::WORD_W-1:0] base_next_ff, base_next_in;
   logic [vtd_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic                       is_data_ff, is_data_in;
   logic                       route_valid_ff, route_valid_in;
   logic                       route_stream_ff, route_stream_in;
   logic                       drop_ff, drop_in;
   logic [1:0]                 rcvd_ff, rcvd_in;

   logic                       accept;
   logic [vtd_pkg::WORD_W-1:0] swapped;
   logic [3:0]                 hdr_kind;
   logic [7:0]                 hdr_misc;
   logic [vtd_pkg::POS_W-1:0]  idx_full;
   logic [vtd_pkg::IDX_W-1:0]  idx;
   logic                       is_last;
   logic [1:0]                 rcvd_set;
   vtd_pkg::err_type           hdr_err;
   vtd_pkg::push_type          push_in;
   logic                       push_err;
   logic                       push_done;

   assign accept   = word_valid & queue_ready;
   assign swapped  = {word_data[7:0], word_data[15:8], word_data[23:16], word_data[31:24]};
   assign hdr_kind = swapped[31:28];
   assign hdr_misc = swapped[27:20];
   assign idx_full = pos_ff - vtd_pkg::PAY_POS;
   assign idx      = idx_full[vtd_pkg::IDX_W-1:0];
   assign is_last  = (idx == vtd_pkg::LAST_IDX);
   assign rcvd_set = rcvd_ff | (route_stream_ff ? 2'b10 : 2'b01);

   always_comb begin
      if (hdr_kind == vtd_pkg::TYPE_DATA) begin
         hdr_err = (hdr_misc != vtd_pkg::MISC_DATA) ? vtd_pkg::ERR_MISC : vtd_pkg::ERR_NONE;
      end else if (hdr_kind == vtd_pkg::TYPE_CTXT) begin
         hdr_err = (hdr_misc != vtd_pkg::MISC_CTXT) ? vtd_pkg::ERR_MISC : vtd_pkg::ERR_NONE;
      end else begin
         hdr_err = vtd_pkg::ERR_TYPE;
      end
   end

   always_comb begin
      base_in         = base_ff;
      base_next_in    = base_next_ff;
      pos_in          = pos_ff;
      is_data_in      = is_data_ff;
      route_valid_in  = route_valid_ff;
      route_stream_in = route_stream_ff;
      drop_in         = drop_ff;
      rcvd_in         = rcvd_ff;
      push_in         = '0;

      if (csr_wr_en) begin
         base_in      = csr_wr_data;
         base_next_in = csr_wr_data + vtd_pkg::WORD_W'(1);
      end

      if (accept) begin
         if (!drop_ff) begin
            if (pos_ff == vtd_pkg::HDR_POS) begin
               if (hdr_err != vtd_pkg::ERR_NONE) begin
                  push_in.push             = 1'b1;
                  push_in.entry.error_code = hdr_err;
                  drop_in                  = 1'b1;
               end else begin
                  is_data_in = (hdr_kind == vtd_pkg::TYPE_DATA);
               end
            end else if (pos_ff == vtd_pkg::SID_POS) begin
               if (is_data_ff) begin
                  if (swapped == base_ff && !rcvd_ff[0]) begin
                     route_valid_in  = 1'b1;
                     route_stream_in = 1'b0;
                  end else if (swapped == base_next_ff && !rcvd_ff[1]) begin
                     route_valid_in  = 1'b1;
                     route_stream_in = 1'b1;
                  end
               end
            end else if (route_valid_ff && pos_ff >= vtd_pkg::PAY_POS &&
                         pos_ff < vtd_pkg::PAY_END) begin
               push_in.push                 = 1'b1;
               push_in.entry.payload_word   = word_data;
               push_in.entry.stream_sel     = route_stream_ff;
               push_in.entry.sample_index   = idx;
               push_in.entry.last_of_packet = is_last;
               push_in.entry.error_code     = vtd_pkg::ERR_NONE;
               if (is_last) begin
                  route_valid_in = 1'b0;
                  if (&rcvd_set) begin
                     push_in.entry.set_complete = 1'b1;
                     rcvd_in                    = 2'b00;
                  end else begin
                     rcvd_in = rcvd_set;
                  end
               end
            end
         end

         if (word_eod) begin
            pos_in          = vtd_pkg::HDR_POS;
            is_data_in      = 1'b0;
            route_valid_in  = 1'b0;
            route_stream_in = 1'b0;
            drop_in         = 1'b0;
         end else if (pos_ff != vtd_pkg::POS_MAX) begin
            pos_in = pos_ff + vtd_pkg::POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff         <= '0;
         base_next_ff    <= vtd_pkg::WORD_W'(1);
         pos_ff          <= vtd_pkg::HDR_POS;
         is_data_ff      <= 1'b0;
         route_valid_ff  <= 1'b0;
         route_stream_ff <= 1'b0;
         drop_ff         <= 1'b0;
         rcvd_ff         <= 2'b00;
      end else begin
         base_ff         <= base_in;
         base_next_ff    <= base_next_in;
         pos_ff          <= pos_in;
         is_data_ff      <= is_data_in;
         route_valid_ff  <= route_valid_in;
         route_stream_ff <= route_stream_in;
         drop_ff         <= drop_in;
         rcvd_ff         <= rcvd_in;
      end
   end

   assign push_out  = push_in;
   assign push_err  = push_in.push & (push_in.entry.error_code != vtd_pkg::ERR_NONE);
   assign push_done = push_in.push & push_in.entry.set_complete;

   `VTD_ASSERT(a_done_on_last, clock, reset, push_done |-> push_in.entry.last_of_packet)
   `VTD_ASSERT(a_err_drops, clock, reset, push_err && !word_eod |=> drop_ff)
   `VTD_NEVER(a_push_needs_accept, clock, reset, push_in.push && !accept)

endmodule

`default_nettype wire

// ===== hdl/vtd_back.sv =====
// back part: result queue and output stream formatting
`default_nettype none
`include "assert_macros.svh"

module vtd_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire vtd_pkg::push_type              push_in_bus,
   output logic                                queue_ready,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [vtd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [vtd_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                rsp_tlast
);

   vtd_pkg::result_type              mem_ff [vtd_pkg::QUEUE_DEPTH];
   logic [vtd_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [vtd_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [vtd_pkg::QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic [vtd_pkg::QUEUE_CNT_W-1:0]  count_less;
   logic                             push;
   logic                             pop;
   vtd_pkg::result_type              head;

   assign queue_ready = (count_ff != vtd_pkg::QUEUE_CNT_W'(vtd_pkg::QUEUE_DEPTH));
   assign push        = push_in_bus.push;
   assign pop         = rsp_tvalid & rsp_tready;
   assign head        = mem_ff[rd_ptr_ff];
   assign count_less  = count_ff - vtd_pkg::QUEUE_CNT_W'(1);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + vtd_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + vtd_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + vtd_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - vtd_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_in_bus.entry;
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {1'b0, head.set_complete, head.sample_index, head.payload_word};
   assign rsp_tuser  = {head.error_code, head.stream_sel};
   assign rsp_tlast  = head.last_of_packet;

   `VTD_NEVER(a_no_overflow, clock, reset, push && !queue_ready)
   `VTD_ASSERT(a_count_drain, clock, reset, pop && !push |=> count_ff == $past(count_less))

endmodule

`default_nettype wire
